// ----- hw/rtl/mcf_pkg.sv -----
// Shared types, constants and helpers for the multifold coincidence finder.
`default_nettype none

package mcf_pkg;

    // Field widths
    localparam int TAG_W      = 63;
    localparam int IDX_W      = 31;
    localparam int CH_FIELD_W = 2;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int NCH_W      = 3;
    localparam int LANES      = 4;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH  = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd1;

    // Request and result codes
    localparam logic OP_TAG     = 1'b0;
    localparam logic OP_END     = 1'b1;
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [CH_FIELD_W-1:0] channel;
        logic [TAG_W-1:0]      tag_value;
    } mcf_in_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic [IDX_W-1:0] index_d;
        logic [IDX_W-1:0] match_number;
    } mcf_out_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic                  is_end;
        logic [CH_FIELD_W-1:0] channel;
        logic [TAG_W-1:0]      tag;
    } mcf_cmd_t;

    // Saturating increment of a stream position or match count
    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
        return (v == {IDX_W{1'b1}}) ? v : v + IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multifold_coincidence_finder_core.sv -----
// Top level of the multifold coincidence finder: registers, front and back.
//
// Input channel s_*: one request per handshake, either a time tag for a channel
// or an end-of-run request that clears the queues, positions and match count.
// Tags for channels outside the number in use are dropped without a result.
// Result channel m_*: a coincidence with the four stream positions and the
// running match count, or a drop flag when a tag meets a full queue.
// Requests pass a two-entry queue into the search engine, so s_ready stays
// high while a result waits, until that queue fills. The engine stores a tag
// in its idle state; each head comparison round then steps through the read
// state (readiness test with the head read), the min/max tree state and the
// spread test state. A tag that completes a match passes the request queue,
// the store, then a full round before its result is registered; each
// discarded head adds another round. End requests need no round. Tag memories
// need no clearing: reset clears only the control state, and the block
// accepts requests as soon as reset is released. A stalled result holds
// the engine before its next result; requests keep filling the queue until
// it is full, then s_ready drops. Configuration writes on cfg_* are taken
// at once; the user must write only while idle; the block does not enforce it.
`default_nettype none

module multifold_coincidence_finder_core
    import mcf_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mcf_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mcf_out_t                  m_data
);

    logic [CFG_W-1:0] window_reg;
    logic [NCH_W-1:0] chan_reg;
    logic [NCH_W-1:0] n_active;
    logic             cmd_valid;
    logic             cmd_pop;
    mcf_cmd_t         cmd;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            chan_reg   <= NCH_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WINDOW:   window_reg <= cfg_wdata;
                REG_CHANNELS: chan_reg   <= cfg_wdata[NCH_W-1:0];
            endcase
        end
    end

    // Clamp the channel count to the supported range
    always_comb begin
        if (chan_reg < NCH_W'(2)) begin
            n_active = NCH_W'(2);
        end else if (chan_reg > NCH_W'(MAX_CHANNELS)) begin
            n_active = NCH_W'(MAX_CHANNELS);
        end else begin
            n_active = chan_reg;
        end
    end

    mcf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .n_active  (n_active),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mcf_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .window    (window_reg),
        .n_active  (n_active),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The engine never takes a request from an empty queue
    a_pop_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("request popped from empty queue");

    // A stalled front always has requests waiting for the engine
    a_stall_has_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> cmd_valid)
        else $error("front stalled with empty queue");

    // The clamped channel count stays within range
    a_active_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_active >= NCH_W'(2)) && (n_active <= NCH_W'(MAX_CHANNELS)))
        else $error("channel count out of range");

    // A drop flag carries no stream positions
    a_drop_no_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind == KIND_DROP)) |->
        ((m_data.index_a == '0) && (m_data.index_b == '0) &&
         (m_data.index_c == '0) && (m_data.index_d == '0)))
        else $error("drop result with nonzero position");

endmodule

`default_nettype wire

// ----- hw/rtl/mcf_front.sv -----
// Front end: accepts requests, drops those for unused channels, queues the rest.
`default_nettype none

module mcf_front
    import mcf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [NCH_W-1:0] n_active,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mcf_in_t          s_data,
    output logic                  cmd_valid,
    output mcf_cmd_t              cmd,
    input  wire logic             cmd_pop
);

    mcf_cmd_t              q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  keep;
    logic                  push;
    mcf_cmd_t              push_cmd;

    localparam logic [CMDQ_PTR_W-1:0] LAST_PTR = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
    localparam logic [CMDQ_CNT_W-1:0] FULL_CNT = CMDQ_CNT_W'(CMDQ_DEPTH);

    // Classify: keep end requests and tags of channels in use
    always_comb begin
        keep = (s_data.op == OP_END) || (NCH_W'(s_data.channel) < n_active);
        push = s_valid && s_ready && keep;
        push_cmd.is_end  = (s_data.op == OP_END);
        push_cmd.channel = s_data.channel;
        push_cmd.tag     = s_data.tag_value;
    end

    assign s_ready   = (count_reg != FULL_CNT);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (push && !cmd_pop) begin
            count_next = count_reg + CMDQ_CNT_W'(1);
        end else if (!push && cmd_pop) begin
            count_next = count_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued requests
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mcf_back.sv -----
// Back end: per-channel tag queues, head search and result register.
`default_nettype none

module mcf_back
    import mcf_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] window,
    input  wire logic [NCH_W-1:0] n_active,
    input  wire logic             cmd_valid,
    input  wire mcf_cmd_t         cmd,
    output logic                  cmd_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mcf_out_t              m_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CH_W   = $clog2(MAX_CHANNELS);

    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_MINMAX = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg [MAX_CHANNELS];
    logic [PTR_W-1:0]  head_next [MAX_CHANNELS];
    logic [FILL_W-1:0] fill_reg [MAX_CHANNELS];
    logic [FILL_W-1:0] fill_next [MAX_CHANNELS];
    logic [IDX_W-1:0]  pos_reg [MAX_CHANNELS];
    logic [IDX_W-1:0]  pos_next [MAX_CHANNELS];
    logic [IDX_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    mcf_out_t          out_data_reg, out_data_next;

    logic [TAG_W-1:0]  lo_reg, lo_next;
    logic [TAG_W-1:0]  hi_reg, hi_next;
    logic [CH_W-1:0]   lo_ch_reg, lo_ch_next;

    logic [TAG_W-1:0]  lane_tag [LANES];
    logic [IDX_W-1:0]  lane_pos [LANES];
    logic [IDX_W-1:0]  lane_idx [LANES];

    logic              wr_en;
    logic [CH_W-1:0]   wr_ch;
    logic [PTR_W-1:0]  wr_ptr;
    logic [SUM_W-1:0]  tail_sum;
    logic              all_ready;
    logic              out_free;
    logic              in_window;
    logic [TAG_W-1:0]  spread;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // Per-channel tag storage, head read registered
    for (genvar g = 0; g < LANES; g++) begin : gen_lane
        if (g < MAX_CHANNELS) begin : gen_used
            logic [TAG_W-1:0] mem [QUEUE_DEPTH];
            logic [TAG_W-1:0] rd_q;
            always_ff @(posedge aclk) begin
                if (wr_en && (wr_ch == CH_W'(g))) begin
                    mem[wr_ptr] <= cmd.tag;
                end
                rd_q <= mem[head_reg[g]];
            end
            assign lane_tag[g] = rd_q;
            assign lane_pos[g] = pos_reg[g];
        end else begin : gen_unused
            assign lane_tag[g] = '0;
            assign lane_pos[g] = '0;
        end
    end

    // Tail slot of the requested channel
    always_comb begin
        wr_ch    = cmd.channel[CH_W-1:0];
        tail_sum = SUM_W'(head_reg[wr_ch]) + SUM_W'(fill_reg[wr_ch]);
        wr_ptr   = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM) : PTR_W'(tail_sum);
    end

    // Check that every channel in use holds a tag
    always_comb begin
        all_ready = 1'b1;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if ((NCH_W'(i) < n_active) && (fill_reg[i] == '0)) begin
                all_ready = 1'b0;
            end
        end
    end

    // Min and max of the heads as a two-level tree; ties go to the lower channel
    always_comb begin
        logic [TAG_W-1:0] mn [LANES];
        logic [TAG_W-1:0] mx [LANES];
        logic [TAG_W-1:0] mn01, mn23, mx01, mx23;
        logic [1:0]       c01, c23, cmin;
        for (int i = 0; i < LANES; i++) begin
            mn[i] = (NCH_W'(i) < n_active) ? lane_tag[i] : {TAG_W{1'b1}};
            mx[i] = (NCH_W'(i) < n_active) ? lane_tag[i] : '0;
        end
        c01  = (mn[1] < mn[0]) ? 2'd1 : 2'd0;
        mn01 = (mn[1] < mn[0]) ? mn[1] : mn[0];
        c23  = (mn[3] < mn[2]) ? 2'd3 : 2'd2;
        mn23 = (mn[3] < mn[2]) ? mn[3] : mn[2];
        cmin = (mn23 < mn01) ? c23 : c01;
        mx01 = (mx[1] > mx[0]) ? mx[1] : mx[0];
        mx23 = (mx[3] > mx[2]) ? mx[3] : mx[2];
        lo_next    = (mn23 < mn01) ? mn23 : mn01;
        hi_next    = (mx23 > mx01) ? mx23 : mx01;
        lo_ch_next = cmin[CH_W-1:0];
    end

    // Spread test and reported positions
    always_comb begin
        spread    = hi_reg - lo_reg;
        in_window = (spread <= TAG_W'(window));
        for (int i = 0; i < LANES; i++) begin
            lane_idx[i] = (NCH_W'(i) < n_active) ? lane_pos[i] : '0;
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // Sequencer: store, clear on end, flag drops, search, report or discard
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_end) begin
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                            head_next[i] = '0;
                            fill_next[i] = '0;
                            pos_next[i]  = '0;
                        end
                        count_next = '0;
                        cmd_pop    = 1'b1;
                    end else if (fill_reg[wr_ch] == FULL_FILL) begin
                        // Queue full: flag the drop once the result slot is free
                        if (out_free) begin
                            out_valid_next             = 1'b1;
                            out_data_next.kind         = KIND_DROP;
                            out_data_next.index_a      = '0;
                            out_data_next.index_b      = '0;
                            out_data_next.index_c      = '0;
                            out_data_next.index_d      = '0;
                            out_data_next.match_number = count_reg;
                            cmd_pop                    = 1'b1;
                        end
                    end else begin
                        wr_en            = 1'b1;
                        fill_next[wr_ch] = fill_reg[wr_ch] + FILL_W'(1);
                        cmd_pop          = 1'b1;
                        state_next       = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = all_ready ? S_MINMAX : S_IDLE;
            end
            S_MINMAX: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (in_window) begin
                    // Report the coincidence and pop every head in use
                    if (out_free) begin
                        out_valid_next             = 1'b1;
                        out_data_next.kind         = KIND_MATCH;
                        out_data_next.index_a      = lane_idx[0];
                        out_data_next.index_b      = lane_idx[1];
                        out_data_next.index_c      = lane_idx[2];
                        out_data_next.index_d      = lane_idx[3];
                        out_data_next.match_number = sat_inc(count_reg);
                        count_next                 = sat_inc(count_reg);
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                            if (NCH_W'(i) < n_active) begin
                                head_next[i] = next_ptr(head_reg[i]);
                                fill_next[i] = fill_reg[i] - FILL_W'(1);
                                pos_next[i]  = sat_inc(pos_reg[i]);
                            end
                        end
                        state_next = S_IDLE;
                    end
                end else begin
                    // Discard the smallest head and search again
                    head_next[lo_ch_reg] = next_ptr(head_reg[lo_ch_reg]);
                    fill_next[lo_ch_reg] = fill_reg[lo_ch_reg] - FILL_W'(1);
                    pos_next[lo_ch_reg]  = sat_inc(pos_reg[lo_ch_reg]);
                    state_next           = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '{default: '0};
            fill_reg      <= '{default: '0};
            pos_reg       <= '{default: '0};
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        lo_ch_reg    <= lo_ch_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
